/* sv/segmentation_overlap_stats_top_macros.svh */
// Assertion macros shared by the segmentation overlap statistics RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef SEGMENTATION_OVERLAP_STATS_TOP_MACROS_SVH
`define SEGMENTATION_OVERLAP_STATS_TOP_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define SOS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SOS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* sv/sos_pkg.sv */
// Package for the segmentation overlap statistics block: payload types and codes.
// Depends on nothing.
`timescale 1ns / 1ps
package sos_pkg;
  localparam int unsigned OutCountBits = 32;
  localparam int unsigned FracBits = 16;

  typedef enum logic [2:0] {
    REG_LOWER = 3'd0, REG_UPPER = 3'd1, REG_SKIP_EN = 3'd2,
    REG_SKIP_AXIS = 3'd3, REG_SKIP_GREATER = 3'd4, REG_SKIP_LIMIT = 3'd5
  } reg_idx_t;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Classification codes passed from front to back.
  typedef enum logic [2:0] {
    CLS_SKIP = 3'd0, CLS_TP = 3'd1, CLS_TN = 3'd2, CLS_FP = 3'd3, CLS_FN = 3'd4
  } cls_t;

  typedef struct packed {
    logic signed [15:0] reference_value;
    logic signed [15:0] test_value;
    logic [9:0] coord_x;
    logic [9:0] coord_y;
    logic [9:0] coord_z;
    logic last_voxel;
  } in_item_t;

  typedef struct packed {
    logic false_pos_flag;
    logic false_neg_flag;
    logic [31:0] count_tp;
    logic [31:0] count_tn;
    logic [31:0] count_fp;
    logic [31:0] count_fn;
    logic [16:0] sensitivity_q16;
    logic [16:0] specificity_q16;
    logic [16:0] jaccard_q16;
    logic [16:0] dice_q16;
    logic signed [19:0] conformity_q16;
    logic [3:0] zero_denominator_mask;
  } out_item_t;

  typedef struct packed {
    cls_t cls;
    logic last;
  } cmd_t;
endpackage

/* sv/sos_front.sv */
// Front end: thresholds values, applies slice skipping and classifies the voxel.
// Depends on sos_pkg.
`timescale 1ns / 1ps
module sos_front #(
  parameter int VALUE_BITS = 16,
  parameter int COORD_BITS = 10
) (
  input  logic signed [VALUE_BITS-1:0] lower_th,
  input  logic signed [VALUE_BITS-1:0] upper_th,
  input  logic skip_en,
  input  logic [1:0] skip_axis,
  input  logic skip_greater,
  input  logic [COORD_BITS-1:0] skip_limit,
  input  logic signed [VALUE_BITS-1:0] ref_v,
  input  logic signed [VALUE_BITS-1:0] tst_v,
  input  logic [COORD_BITS-1:0] cx,
  input  logic [COORD_BITS-1:0] cy,
  input  logic [COORD_BITS-1:0] cz,
  input  logic last,
  output sos_pkg::cmd_t cmd
);
  import sos_pkg::*;
  logic ref_in, tst_in, skip;
  logic [COORD_BITS-1:0] c;

  always_comb begin
    ref_in = (ref_v >= lower_th) && (ref_v <= upper_th);
    tst_in = (tst_v >= lower_th) && (tst_v <= upper_th);
    case (skip_axis)
      AXIS_X: c = cx;
      AXIS_Y: c = cy;
      default: c = cz;
    endcase
    skip = skip_en && (skip_axis != 2'd3) &&
           (skip_greater ? (c > skip_limit) : (c < skip_limit));
    cmd.last = last;
    if (skip) cmd.cls = CLS_SKIP;
    else if (ref_in && tst_in) cmd.cls = CLS_TP;
    else if (!ref_in && !tst_in) cmd.cls = CLS_TN;
    else if (tst_in) cmd.cls = CLS_FP;
    else cmd.cls = CLS_FN;
  end
endmodule

/* sv/sos_queue.sv */
// Two-entry queue carrying classified voxels from front to back end.
// Depends on sos_pkg and the macros header.
`timescale 1ns / 1ps
module sos_queue (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  sos_pkg::cmd_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output sos_pkg::cmd_t rd_data
);
  import sos_pkg::*;
  `include "segmentation_overlap_stats_top_macros.svh"
  cmd_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

  `SOS_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= 2'd2)
  `SOS_ASSERT_NXT(a_fill, clk, rst_n, wr && !rd, cnt_r == $past(cnt_r) + 2'd1)
  `SOS_ASSERT_IMP(a_ptr, clk, rst_n, cnt_r == 2'd0 || cnt_r == 2'd2, wp_r == rp_r)
endmodule

/* sv/sos_div.sv */
// Iterative restoring divider producing a rounded Q.16 quotient, one bit a cycle.
// Imports sos_pkg but uses none of its constants.
`timescale 1ns / 1ps
module sos_div #(
  parameter int W = 36
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic busy,
  output logic [19:0] quo
);
  import sos_pkg::*;
  // 4 integer bits + 16 fraction bits + 1 rounding bit = 21 steps.
  localparam int Steps = 21;
  logic [W+1:0] rem_r;
  logic [W-1:0] den_r;
  logic [W-1:0] numsh_r;
  logic [Steps-1:0] q_r;
  logic [4:0] k_r;
  logic [W+1:0] trial;

  assign busy = k_r != 5'd0;
  assign trial = {rem_r[W:0], numsh_r[W-1]} - {2'b00, den_r};
  assign quo = 20'(({1'b0, q_r} + 22'd1) >> 1);

  always_ff @(posedge clk) begin
    if (start) begin
      // The quotient is below 16, so num >> 4 is already smaller than den and
      // can seed the remainder; the low 4 bits of num are shifted in first.
      rem_r <= {2'b00, num >> 4};
      den_r <= den;
      numsh_r <= num << (W - 4);
      q_r <= '0;
    end else if (busy) begin
      numsh_r <= numsh_r << 1;
      if (!trial[W+1]) begin
        rem_r <= trial;
        q_r <= {q_r[Steps-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[W:0], numsh_r[W-1]};
        q_r <= {q_r[Steps-2:0], 1'b0};
      end
    end
    if (!rst_n) k_r <= 5'd0;
    else if (start) k_r <= 5'(Steps);
    else if (busy) k_r <= k_r - 5'd1;
  end
endmodule

/* sv/sos_back.sv */
// Back end: saturating counters and end-of-image ratio computation.
// Depends on sos_pkg, sos_div and the macros header.
`timescale 1ns / 1ps
module sos_back #(
  parameter int COUNT_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  sos_pkg::cmd_t cmd,
  output logic out_valid,
  input  logic out_ready,
  output sos_pkg::out_item_t out_data
);
  import sos_pkg::*;
  `include "segmentation_overlap_stats_top_macros.svh"
  localparam int DW = COUNT_BITS + 4;
  localparam logic [COUNT_BITS-1:0] Max = '1;

  typedef enum logic [2:0] {S_RUN, S_DIV, S_WAIT, S_NEXT, S_OUT} st_t;
  st_t st_r;
  logic [COUNT_BITS-1:0] tp_r, tn_r, fp_r, fn_r;
  logic [2:0] job_r;
  out_item_t res_r;
  logic vld_r;
  logic div_start_r;
  logic [DW-1:0] num, den;
  logic dbusy;
  logic [19:0] q;
  logic [DW-1:0] tpx, tnx, fpx, fnx;
  logic take;
  logic ctp, ctn, cfp, cfn;
  logic conf_sat;

  assign tpx = DW'(tp_r);
  assign tnx = DW'(tn_r);
  assign fpx = DW'(fp_r);
  assign fnx = DW'(fn_r);
  assign conf_sat = (fpx + fnx) >= (tpx * DW'(9));

  always_comb begin
    case (job_r)
      3'd0: begin num = tpx; den = tpx + fnx; end
      3'd1: begin num = tnx; den = tnx + fpx; end
      3'd2: begin num = tpx; den = tpx + fpx + fnx; end
      3'd3: begin num = tpx << 1; den = (tpx << 1) + fpx + fnx; end
      default: begin num = fpx + fnx; den = tpx; end
    endcase
  end

  sos_div #(.W(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start_r), .num(num), .den(den),
    .busy(dbusy), .quo(q)
  );

  assign cmd_ready = (st_r == S_RUN) && !(vld_r && !out_ready);
  assign take = cmd_valid && cmd_ready;
  assign out_valid = vld_r;
  assign out_data = res_r;
  assign ctp = take && cmd.cls == CLS_TP;
  assign ctn = take && cmd.cls == CLS_TN;
  assign cfp = take && cmd.cls == CLS_FP;
  assign cfn = take && cmd.cls == CLS_FN;

  function automatic logic [31:0] oc(input logic [COUNT_BITS-1:0] c);
    if (COUNT_BITS > 32 && (c >> 32) != 0) return '1;
    return 32'(c);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_RUN;
      vld_r <= 1'b0;
      div_start_r <= 1'b0;
      tp_r <= '0; tn_r <= '0; fp_r <= '0; fn_r <= '0;
      job_r <= 3'd0;
    end else begin
      if (vld_r && out_ready && !take) vld_r <= 1'b0;
      unique case (st_r)
        S_RUN: begin
          if (take) begin
            if (ctp && tp_r != Max) tp_r <= tp_r + 1'b1;
            if (ctn && tn_r != Max) tn_r <= tn_r + 1'b1;
            if (cfp && fp_r != Max) fp_r <= fp_r + 1'b1;
            if (cfn && fn_r != Max) fn_r <= fn_r + 1'b1;
            res_r <= out_item_t'({cfp, cfn, ($bits(out_item_t) - 2)'(0)});
            // A waiting result is always taken on the same edge as a command.
            vld_r <= !cmd.last;
            if (cmd.last) begin
              job_r <= 3'd0;
              st_r <= S_NEXT;
            end
          end
        end
        S_NEXT: begin
          res_r.count_tp <= oc(tp_r);
          res_r.count_tn <= oc(tn_r);
          res_r.count_fp <= oc(fp_r);
          res_r.count_fn <= oc(fn_r);
          if (den == '0) begin
            if (job_r == 3'd4) res_r.conformity_q16 <= '0;
            else res_r.zero_denominator_mask[job_r[1:0]] <= 1'b1;
            if (job_r == 3'd4) st_r <= S_OUT;
            else job_r <= job_r + 3'd1;
          end else if (job_r == 3'd4 && conf_sat) begin
            res_r.conformity_q16 <= -20'sd524288;
            st_r <= S_OUT;
          end else begin
            div_start_r <= 1'b1;
            st_r <= S_DIV;
          end
        end
        S_DIV: begin
          div_start_r <= 1'b0;
          st_r <= S_WAIT;
        end
        S_WAIT: begin
          if (!dbusy) begin
            case (job_r)
              3'd0: res_r.sensitivity_q16 <= q[16:0];
              3'd1: res_r.specificity_q16 <= q[16:0];
              3'd2: res_r.jaccard_q16 <= q[16:0];
              3'd3: res_r.dice_q16 <= q[16:0];
              default: begin
                if ($signed({1'b0, q}) > 21'sd589824)
                  res_r.conformity_q16 <= -20'sd524288;
                else
                  res_r.conformity_q16 <= 20'(21'sd65536 - $signed({1'b0, q}));
              end
            endcase
            if (job_r == 3'd4) st_r <= S_OUT;
            else begin
              job_r <= job_r + 3'd1;
              st_r <= S_NEXT;
            end
          end
        end
        S_OUT: begin
          if (!vld_r) begin
            vld_r <= 1'b1;
            tp_r <= '0; tn_r <= '0; fp_r <= '0; fn_r <= '0;
            st_r <= S_RUN;
          end
        end
        default: st_r <= S_RUN;
      endcase
    end
  end

  `SOS_ASSERT_IMP(a_no_take_busy, clk, rst_n, st_r != S_RUN, !cmd_ready)
  `SOS_ASSERT_NXT(a_out_hold, clk, rst_n, vld_r && !out_ready, vld_r && $stable(res_r))
  `SOS_ASSERT_IMP(a_flags_excl, clk, rst_n, vld_r,
                  !(res_r.false_pos_flag && res_r.false_neg_flag))
endmodule

/* sv/segmentation_overlap_stats_top.sv */
// Top level of the segmentation overlap statistics block.
// Depends on sos_pkg, sos_front, sos_queue and sos_back.
`timescale 1ns / 1ps
// Each input transaction carries a reference and a test voxel value with their
// coordinates. The front end thresholds both values, applies optional slice
// skipping and classifies the voxel as true/false positive/negative in the
// same cycle it is accepted; a two-entry queue decouples it from the back end,
// which updates saturating counters and returns one result transaction per
// voxel. The stream runs at one voxel per cycle unless a waiting result is not
// taken or an image is ending. On the last voxel the back end runs up to five
// divisions through a single shared bit-serial divider, then issues its result
// and clears the counters. Ratios are Q1.16 (conformity signed Q4.16), rounded
// to nearest with ties up; a zero denominator reads 0 and sets its mask bit
// (none for conformity). Configuration registers are written through cfg_we,
// cfg_index and cfg_wdata; the user must do so only while idle (not enforced).
module segmentation_overlap_stats_top #(
  parameter int COUNT_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sos_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output sos_pkg::out_item_t out_data,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_wdata
);
  import sos_pkg::*;
  logic signed [15:0] lower_r, upper_r;
  logic skip_en_r, skip_greater_r;
  logic [1:0] skip_axis_r;
  logic [9:0] skip_limit_r;
  cmd_t fcmd, qcmd;
  logic q_valid, q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r <= 16'sd1;
      upper_r <= 16'sd32767;
      skip_en_r <= 1'b0;
      skip_axis_r <= AXIS_X;
      skip_greater_r <= 1'b1;
      skip_limit_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOWER: lower_r <= cfg_wdata;
        REG_UPPER: upper_r <= cfg_wdata;
        REG_SKIP_EN: skip_en_r <= cfg_wdata[0];
        REG_SKIP_AXIS: skip_axis_r <= cfg_wdata[1:0];
        REG_SKIP_GREATER: skip_greater_r <= cfg_wdata[0];
        REG_SKIP_LIMIT: skip_limit_r <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  sos_front #(.VALUE_BITS(16), .COORD_BITS(10)) u_front (
    .lower_th(lower_r), .upper_th(upper_r),
    .skip_en(skip_en_r), .skip_axis(skip_axis_r), .skip_greater(skip_greater_r),
    .skip_limit(skip_limit_r), .ref_v(in_data.reference_value),
    .tst_v(in_data.test_value), .cx(in_data.coord_x), .cy(in_data.coord_y),
    .cz(in_data.coord_z), .last(in_data.last_voxel), .cmd(fcmd)
  );

  sos_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_valid(in_valid), .wr_ready(in_ready),
    .wr_data(fcmd), .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(qcmd)
  );

  sos_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(q_valid), .cmd_ready(q_ready),
    .cmd(qcmd), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );
endmodule
